// ===== rtl/sgcb_pkg.sv =====
// sgcb_pkg: shared widths, types and the srgb decode table for the gamma-correct blender
// used by every module under rtl/; no dependencies
`default_nettype none

package sgcb_pkg;

	localparam int LINEAR_BITS = 12;
	localparam int WEIGHT_BITS = 8;
	localparam int CODE_BITS   = 8;
	localparam int WIN_BITS    = 9;
	localparam int COLOR_BITS  = 32;
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 32;

	localparam int LIN_MAX = (1 << LINEAR_BITS) - 1;
	localparam int W_FULL  = 1 << WEIGHT_BITS;
	localparam int W_HALF  = W_FULL / 2;

	// search stages, then the whole lane depth: the decode and blend stages plus the search stages
	localparam int SRCH_STAGES = CODE_BITS;
	localparam int PIPE_DEPTH  = 2 + SRCH_STAGES;

	localparam int PROD_W  = LINEAR_BITS + WEIGHT_BITS + 1;
	localparam int APROD_W = CODE_BITS + WEIGHT_BITS + 1;

	typedef logic [LINEAR_BITS-1:0] lin_t;
	typedef logic [WEIGHT_BITS:0]   wgt_t;
	typedef logic [CODE_BITS-1:0]   code_t;
	typedef logic [(1 << CODE_BITS)-1:0][LINEAR_BITS-1:0] dec_tab_t;

	typedef struct packed {
		code_t red;
		code_t green;
		code_t blue;
		code_t alpha;
	} pix_t;

	// srgb to linear, fixed point, worked out at elaboration
	function automatic dec_tab_t build_dec_tab();
		dec_tab_t    tab;
		logic [63:0] n;
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] p;
		logic [63:0] lin;
		logic [63:0] s;
		int          c;
		int          it;
		int          j;
		s = 64'(LIN_MAX);
		for (c = 0; c < (1 << CODE_BITS); c++) begin
			if (c <= 10) begin
				tab[c] = LINEAR_BITS'((64'(20 * c) * s + 64'd32946) / 64'd65892);
			end else if (c == (1 << CODE_BITS) - 1) begin
				tab[c] = LINEAR_BITS'(s);
			end else begin
				n  = 64'(1000 * c + 14025);
				u  = (n << 32) / 64'd269025;
				u2 = (u * u) >> 32;
				lo = 64'd0;
				hi = 64'hFFFF_FFFF;
				for (it = 0; it < 33; it++) begin
					if (lo < hi) begin
						mid = lo + ((hi - lo + 64'd1) >> 1);
						p   = mid;
						for (j = 0; j < 4; j++) begin
							p = (p * mid) >> 32;
						end
						if (p <= u2) begin
							lo = mid;
						end else begin
							hi = mid - 64'd1;
						end
					end
				end
				lin    = (u2 * lo) >> 32;
				tab[c] = LINEAR_BITS'((lin * s + 64'h8000_0000) >> 32);
			end
		end
		return tab;
	endfunction

	localparam dec_tab_t DEC_TAB = build_dec_tab();

endpackage

`default_nettype wire

// ===== rtl/sgcb_chan_lane.sv =====
// sgcb_chan_lane: one colour channel - decode, linear blend, binary search re-encode
// depends on sgcb_pkg (decode table, widths)
`default_nettype none

module sgcb_chan_lane
	import sgcb_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  en,
	input  wire code_t code_a,
	input  wire code_t code_b,
	input  wire wgt_t  wgt,
	output code_t      code_out
);

	lin_t lin_a_s1;
	lin_t lin_b_s1;
	wgt_t wgt_s1;
	lin_t lin_s2;

	// index 0 is stage 3, last index is stage 10
	code_t srch_code_s [SRCH_STAGES];
	lin_t  srch_lin_s  [SRCH_STAGES];

	logic [PROD_W-1:0] blend_sum;

	always_ff @(posedge clk) begin
		if (en) begin
			lin_a_s1 <= DEC_TAB[code_a];
			lin_b_s1 <= DEC_TAB[code_b];
			wgt_s1   <= wgt;
		end
	end

	assign blend_sum = PROD_W'(lin_a_s1) * PROD_W'(wgt_t'(W_FULL) - wgt_s1)
		+ PROD_W'(lin_b_s1) * PROD_W'(wgt_s1) + PROD_W'(W_HALF);

	always_ff @(posedge clk) begin
		if (en) begin
			lin_s2 <= blend_sum[LINEAR_BITS+WEIGHT_BITS-1:WEIGHT_BITS];
		end
	end

	// one code bit per stage, msb first; entry 0 always fits
	for (genvar g = 0; g < SRCH_STAGES; g++) begin : g_srch
		code_t prev_code;
		lin_t  prev_lin;
		code_t cand;
		if (g == 0) begin : g_first
			assign prev_code = '0;
			assign prev_lin  = lin_s2;
		end else begin : g_next
			assign prev_code = srch_code_s[g-1];
			assign prev_lin  = srch_lin_s[g-1];
		end
		assign cand = prev_code | (code_t'(1) << (SRCH_STAGES - 1 - g));
		always_ff @(posedge clk) begin
			if (en) begin
				srch_code_s[g] <= (DEC_TAB[cand] <= prev_lin) ? cand : prev_code;
				srch_lin_s[g]  <= prev_lin;
			end
		end
	end

	assign code_out = srch_code_s[SRCH_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/sgcb_alpha_lane.sv =====
// sgcb_alpha_lane: straight alpha interpolation, delayed to line up with the colour lanes
// depends on sgcb_pkg (widths, pipeline depth)
`default_nettype none

module sgcb_alpha_lane
	import sgcb_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  en,
	input  wire code_t alpha_a,
	input  wire code_t alpha_b,
	input  wire wgt_t  wgt,
	output code_t      alpha_out
);

	logic [APROD_W-1:0] mix;
	code_t              alpha_s [PIPE_DEPTH];

	assign mix = APROD_W'(alpha_a) * APROD_W'(wgt_t'(W_FULL) - wgt)
		+ APROD_W'(alpha_b) * APROD_W'(wgt);

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s[0] <= mix[CODE_BITS+WEIGHT_BITS-1:WEIGHT_BITS];
			for (int i = 1; i < PIPE_DEPTH; i++) begin
				alpha_s[i] <= alpha_s[i-1];
			end
		end
	end

	assign alpha_out = alpha_s[PIPE_DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/sgcb_out_skid.sv =====
// sgcb_out_skid: takes the pixel merged from the lane results and holds it in an output/skid pair
// depends on sgcb_pkg (pix_t)
`default_nettype none

module sgcb_out_skid
	import sgcb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire pix_t               in_pix,
	input  wire logic               m_tready,
	output logic                    m_tvalid,
	output logic [OUT_TDATA_W-1:0]  m_tdata,
	output logic                    en
);

	logic out_valid_q;
	logic skid_valid_q;
	pix_t out_pix_q;
	pix_t skid_pix_q;
	logic take;
	logic incoming;

	assign en       = !skid_valid_q;
	assign take     = out_valid_q && m_tready;
	assign incoming = en && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (incoming) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (incoming && (!out_valid_q || take)) begin
			out_pix_q <= in_pix;
		end else if (incoming) begin
			skid_pix_q <= in_pix;
		end else if (take && skid_valid_q) begin
			out_pix_q <= skid_pix_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_pix_q);

`ifndef ASSERT_OFF
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a beat while the output register is empty");

	a_skid_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(incoming && out_valid_q && !m_tready) |=> skid_valid_q)
		else $error("arriving beat lost while output stalled");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && m_tready) |=> (out_valid_q && !skid_valid_q))
		else $error("skid beat not moved to the output register");
`endif

endmodule

`default_nettype wire

// ===== rtl/srgb_gamma_correct_color_blend_top.sv =====
// srgb_gamma_correct_color_blend_top: gamma-correct rgba8888 blend, one beat per clock while the skid stage is empty
// path: an accepted input beat passes the 10 lane stages, then the output register, to m_axis_tvalid
// throughput: one beat per cycle while the skid stage is empty; each search stage is one table read with a compare
// back-pressure: an output/skid pair decouples the sides, s_axis_tready is a flop output
// reset: arst_n clears the stage valid bits and the output/skid valids; payload is not reset
// depends on sgcb_pkg, sgcb_chan_lane, sgcb_alpha_lane, sgcb_out_skid
`default_nettype none

module srgb_gamma_correct_color_blend_top
	import sgcb_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// slave side
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// color_a [31:0], color_b [63:32], blend_weight [72:64], zero pad [79:73]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// master side
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// blended_color [31:0]
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	logic [COLOR_BITS-1:0] color_a;
	logic [COLOR_BITS-1:0] color_b;
	logic [WIN_BITS-1:0]   blend_weight;
	wgt_t                  wgt_sat;
	logic                  en;
	logic                  accept;

	// one valid bit per lane stage, index 0 is stage 1
	logic [PIPE_DEPTH-1:0] vld_s;

	pix_t lane_pix;

	// unpack the input beat
	assign color_a      = s_axis_tdata[COLOR_BITS-1:0];
	assign color_b      = s_axis_tdata[2*COLOR_BITS-1:COLOR_BITS];
	assign blend_weight = s_axis_tdata[2*COLOR_BITS+WIN_BITS-1:2*COLOR_BITS];

	// weight above full scale clamps to fully color_b
	always_comb begin
		if ((WEIGHT_BITS+WIN_BITS+1)'(blend_weight) > (WEIGHT_BITS+WIN_BITS+1)'(W_FULL)) begin
			wgt_sat = wgt_t'(W_FULL);
		end else begin
			wgt_sat = wgt_t'(blend_weight);
		end
	end

	// the whole lane pipeline moves only while the skid stage is empty
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_DEPTH-2:0], accept};
		end
	end

	// three colour lanes side by side: red, green, blue
	sgcb_chan_lane u_lane_red (
		.clk      (clk),
		.en       (en),
		.code_a   (color_a[31:24]),
		.code_b   (color_b[31:24]),
		.wgt      (wgt_sat),
		.code_out (lane_pix.red)
	);

	sgcb_chan_lane u_lane_green (
		.clk      (clk),
		.en       (en),
		.code_a   (color_a[23:16]),
		.code_b   (color_b[23:16]),
		.wgt      (wgt_sat),
		.code_out (lane_pix.green)
	);

	sgcb_chan_lane u_lane_blue (
		.clk      (clk),
		.en       (en),
		.code_a   (color_a[15:8]),
		.code_b   (color_b[15:8]),
		.wgt      (wgt_sat),
		.code_out (lane_pix.blue)
	);

	// alpha has no gamma, just a delayed linear mix
	sgcb_alpha_lane u_lane_alpha (
		.clk       (clk),
		.en        (en),
		.alpha_a   (color_a[7:0]),
		.alpha_b   (color_b[7:0]),
		.wgt       (wgt_sat),
		.alpha_out (lane_pix.alpha)
	);

	// merge lanes into one pixel and buffer it for the master side
	sgcb_out_skid u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s[PIPE_DEPTH-1]),
		.in_pix   (lane_pix),
		.m_tready (m_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tdata  (m_axis_tdata),
		.en       (en)
	);

endmodule

`default_nettype wire

// ===== bench/srgb_gamma_correct_color_blend_top_test.sv =====
`timescale 1ns / 100ps
// srgb_gamma_correct_color_blend_top_test: self-checking bench for the gamma-correct rgba blender
// predicts each output beat from its own srgb decode table and checks it in order
// depends on sgcb_pkg and srgb_gamma_correct_color_blend_top

module srgb_gamma_correct_color_blend_top_test;

	import sgcb_pkg::IN_TDATA_W;
	import sgcb_pkg::OUT_TDATA_W;

	// predictor scaling: linear full scale and weight full scale
	localparam bit [63:0] LIN_FULL    = 64'd4095;
	localparam bit [63:0] WEIGHT_FULL = 64'd256;
	localparam int        WEIGHT_SH   = 8;
	// output lane depth plus margin, for the drain at the end
	localparam int        DRAIN_CYCLES = 24;

	// holds the decode table and the queue of pixels still owed by the block
	class blend_predictor;
		bit [11:0] decode_lut [256];
		bit [31:0] expected_pixels [$];
		int        mismatches;

		function new();
			bit [63:0] n;
			bit [63:0] u;
			bit [63:0] u2;
			bit [63:0] lo;
			bit [63:0] hi;
			bit [63:0] mid;
			bit [63:0] p;
			bit [63:0] lin;
			mismatches = 0;
			for (int c = 0; c < 256; c++) begin
				if (c <= 10) begin
					decode_lut[c] = 12'((64'(20 * c) * LIN_FULL + 64'd32946) / 64'd65892);
				end else if (c == 255) begin
					decode_lut[c] = 12'(LIN_FULL);
				end else begin
					// u = (c/255 + 0.055)/1.055 in q0.32, linear = u^2.4 = u^2 * fifth root of u^2
					n  = 64'(1000 * c + 14025);
					u  = (n << 32) / 64'd269025;
					u2 = (u * u) >> 32;
					lo = 64'd0;
					hi = 64'hFFFF_FFFF;
					while (lo < hi) begin
						mid = lo + (hi - lo + 64'd1) / 64'd2;
						p   = mid;
						for (int i = 0; i < 4; i++) begin
							p = (p * mid) >> 32;
						end
						if (p <= u2) begin
							lo = mid;
						end else begin
							hi = mid - 64'd1;
						end
					end
					lin           = (u2 * lo) >> 32;
					decode_lut[c] = 12'((lin * LIN_FULL + 64'h8000_0000) >> 32);
				end
			end
		endfunction

		// code = how many table entries above zero sit at or below the linear value
		function bit [7:0] encode_linear(bit [63:0] l);
			int cnt;
			cnt = 0;
			for (int k = 1; k < 256; k++) begin
				if (64'(decode_lut[k]) <= l) begin
					cnt++;
				end
			end
			return 8'(cnt);
		endfunction

		function bit [7:0] mix_channel(bit [7:0] ca, bit [7:0] cb, bit [63:0] w);
			bit [63:0] l;
			l = (64'(decode_lut[ca]) * (WEIGHT_FULL - w) + 64'(decode_lut[cb]) * w
				+ WEIGHT_FULL / 2) >> WEIGHT_SH;
			return encode_linear(l);
		endfunction

		function void note_pixel_pair(bit [31:0] a, bit [31:0] b, bit [8:0] w_in);
			bit [63:0] w;
			bit [63:0] al;
			bit [31:0] px;
			w = 64'(w_in);
			if (w > WEIGHT_FULL) begin
				w = WEIGHT_FULL;
			end
			px[31:24] = mix_channel(a[31:24], b[31:24], w);
			px[23:16] = mix_channel(a[23:16], b[23:16], w);
			px[15:8]  = mix_channel(a[15:8], b[15:8], w);
			al        = (64'(a[7:0]) * (WEIGHT_FULL - w) + 64'(b[7:0]) * w) >> WEIGHT_SH;
			px[7:0]   = al[7:0];
			expected_pixels.push_back(px);
		endfunction

		function void check_pixel(bit [31:0] got);
			bit [31:0] want;
			if (expected_pixels.size() == 0) begin
				$error("blended_color beat %h arrived with nothing outstanding", got);
				mismatches++;
				return;
			end
			want = expected_pixels.pop_front();
			if (got !== want) begin
				$error("blended_color expected %h actual %h", want, got);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return expected_pixels.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// color_a [31:0], color_b [63:32], blend_weight [72:64], zero pad [79:73]
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// blended_color [31:0]
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// idle rates in percent per cycle, changed between phases
	int sender_idle_pct   = 22;
	int receiver_idle_pct = 78;

	blend_predictor sb;

	srgb_gamma_correct_color_blend_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// input monitor: every accepted beat gets its expected pixel
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			sb.note_pixel_pair(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[72:64]);
		end
	end

	// output side: check the accepted beat, then pick ready for the next cycle
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_pixel(m_axis_tdata);
		end
		m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	// offers one pixel pair after a random gap and holds it until the block takes it
	task automatic send_pixel_pair(input bit [31:0] a, input bit [31:0] b, input bit [8:0] w);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'b0, w, b, a};
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
	endtask

	// bytes lean towards black, white and the linear toe of the curve
	function automatic bit [7:0] pick_code();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'($urandom_range(10));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic bit [31:0] pick_color();
		return {pick_code(), pick_code(), pick_code(), pick_code()};
	endfunction

	// weights mostly in range, with the end points and over-range values mixed in
	function automatic bit [8:0] pick_weight();
		case ($urandom_range(9))
			0: return 9'($urandom_range(511, 257));
			1: return $urandom_range(1) ? 9'd256 : 9'd0;
			default: return 9'($urandom_range(256));
		endcase
	endfunction

	task automatic run_random(input int count);
		bit [31:0] a;
		for (int i = 0; i < count; i++) begin
			a = pick_color();
			// every eighth pair or so blends a colour with itself
			if ($urandom_range(7) == 0) begin
				send_pixel_pair(a, a, pick_weight());
			end else begin
				send_pixel_pair(a, pick_color(), pick_weight());
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: weight end points, each weight bit, over-range weights
		send_pixel_pair(32'h0000_0000, 32'h0000_0000, 9'd0);
		send_pixel_pair(32'hFFFF_FFFF, 32'h0000_0000, 9'd0);
		send_pixel_pair(32'hFFFF_FFFF, 32'h0000_0000, 9'd256);
		send_pixel_pair(32'hFFFF_FFFF, 32'h0000_0000, 9'd128);
		send_pixel_pair(32'h0000_0000, 32'hFFFF_FFFF, 9'd128);
		for (int i = 0; i < 9; i++) begin
			send_pixel_pair(32'h00FF_00FF, 32'hFF00_FF00, 9'(1 << i));
		end
		send_pixel_pair(32'h1234_5678, 32'hFEDC_BA98, 9'd257);
		send_pixel_pair(32'h1234_5678, 32'hFEDC_BA98, 9'd511);
		// linear toe of the curve and its edge
		send_pixel_pair(32'h0A0A_0A0A, 32'h0B0B_0B0B, 9'd128);
		send_pixel_pair(32'h0102_0304, 32'h0506_0708, 9'd77);
		// equal colours answer their own codes
		send_pixel_pair(32'h8040_C020, 32'h8040_C020, 9'd100);
		send_pixel_pair(32'h0105_09FE, 32'h0105_09FE, 9'd200);
		send_pixel_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd511);

		run_random(610);
		sender_idle_pct   = 78;
		receiver_idle_pct = 22;
		run_random(610);
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		run_random(610);
		s_axis_tvalid <= 1'b0;

		// drain, then give any stray beat time to show up
		while (sb.outstanding() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
